/* hw/rtl/osti_pkg.sv */
package osti_pkg;

  localparam int unsigned CordSteps = 20;

  localparam logic signed [32:0] CORD_GAIN = 33'sd652032874;
  localparam logic signed [63:0] COEF_ONE  = 64'sd65536;
  localparam logic signed [63:0] POS_MAX   = 64'sd134217727;
  localparam logic signed [63:0] VEL_MAX   = 64'sd16777215;

  localparam logic [2:0] CFG_ARGP = 3'd0;
  localparam logic [2:0] CFG_INCL = 3'd1;
  localparam logic [2:0] CFG_NODE = 3'd2;
  localparam logic [2:0] CFG_SMA  = 3'd3;
  localparam logic [2:0] CFG_ECC  = 3'd4;
  localparam logic [2:0] CFG_MU   = 3'd5;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [24:0] z;
  } cord_t;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } sc_t;

  // m holds M0 M1 M3 M4 M6 M7 of the rotation, row by row
  typedef struct packed {
    logic              busy;
    logic [31:0]       scale;
    logic [15:0]       ecc;
    logic [5:0][17:0]  m;
  } coef_t;

  function automatic logic signed [24:0] atan_lut(input logic [4:0] i);
    logic signed [24:0] a;
    case (i)
      5'd0:  a = 25'sd2097152;
      5'd1:  a = 25'sd1238021;
      5'd2:  a = 25'sd654136;
      5'd3:  a = 25'sd332050;
      5'd4:  a = 25'sd166669;
      5'd5:  a = 25'sd83416;
      5'd6:  a = 25'sd41718;
      5'd7:  a = 25'sd20860;
      5'd8:  a = 25'sd10430;
      5'd9:  a = 25'sd5215;
      5'd10: a = 25'sd2608;
      5'd11: a = 25'sd1304;
      5'd12: a = 25'sd652;
      5'd13: a = 25'sd326;
      5'd14: a = 25'sd163;
      5'd15: a = 25'sd81;
      5'd16: a = 25'sd41;
      5'd17: a = 25'sd20;
      5'd18: a = 25'sd10;
      5'd19: a = 25'sd5;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

  function automatic cord_t cordic_init(input logic [15:0] ang);
    cord_t v;
    v.x = CORD_GAIN;
    v.y = '0;
    v.z = $signed({3'b000, ang[13:0], 8'h00});
    return v;
  endfunction

  function automatic cord_t cordic_step(input cord_t v, input logic [4:0] i);
    cord_t o;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[24]) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - atan_lut(i);
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + atan_lut(i);
    end
    return o;
  endfunction

  // divide by 2^sh, rounding half away from zero
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] q;
    half = 64'd1 << (sh - 1);
    mag  = v[63] ? $unsigned(-v) : $unsigned(v);
    q    = (mag + half) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    logic signed [63:0] o;
    if (v > lim) begin
      o = lim;
    end else if (v < -lim) begin
      o = -lim;
    end else begin
      o = v;
    end
    return o;
  endfunction

  function automatic sc_t cordic_finish(input logic signed [32:0] x,
                                        input logic signed [32:0] y,
                                        input logic [1:0] quad);
    logic signed [32:0] cq;
    logic signed [32:0] sq;
    sc_t o;
    case (quad)
      2'd0: begin
        cq = x;
        sq = y;
      end
      2'd1: begin
        cq = -y;
        sq = x;
      end
      2'd2: begin
        cq = -x;
        sq = -y;
      end
      default: begin
        cq = y;
        sq = -x;
      end
    endcase
    o.c = 18'(clamp64(rnd64(64'(cq), 14), COEF_ONE));
    o.s = 18'(clamp64(rnd64(64'(sq), 14), COEF_ONE));
    return o;
  endfunction

endpackage

/* hw/rtl/orbit_state_to_inertial_frame.sv */
// Turns an orbit sample (radius, true anomaly) into inertial position in meters and
// velocity in mm/s, using the orbit elements held in the configuration registers.
// The datapath takes one item per clock while neither coef.busy nor out_stall_i holds it:
// a 20-stage pipelined CORDIC for the anomaly, then five stages of multiply, round and
// clamp. After reset and after every configuration write to one of the six element
// registers the rotation coefficients and the velocity scale are recomputed by a shared
// sequential unit (three 20-step CORDIC runs, six matrix entries, a 102-step divider and
// a 32-step square root), and input stays stalled until that is done.
module orbit_state_to_inertial_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [49:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [26:0]        orbit_radius_i,
  input  logic [15:0]        true_anomaly_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [27:0] pos_x_o,
  output logic signed [27:0] pos_y_o,
  output logic signed [27:0] pos_z_o,
  output logic signed [24:0] vel_x_o,
  output logic signed [24:0] vel_y_o,
  output logic signed [24:0] vel_z_o,
  output logic               vel_saturated_o
);

  localparam int unsigned NSt = osti_pkg::CordSteps + 1;

  osti_pkg::coef_t coef;

  logic adv, accept;

  osti_pkg::cord_t cord_q [NSt];
  logic [1:0]      quad_q [NSt];
  logic [26:0]     r_q    [NSt];
  logic            vld_q  [NSt];

  logic               a_vld_q;
  logic signed [17:0] cv_q, sv_q, vx_q;
  logic signed [18:0] vy_q;
  logic [26:0]        a_r_q;
  osti_pkg::sc_t      sc_a;

  logic               b_vld_q;
  logic signed [34:0] t_q [3];
  logic signed [35:0] u_q [3];
  logic [26:0]        b_r_q;

  logic               c_vld_q;
  logic [43:0]        pl_q [3];
  logic signed [44:0] ph_q [3];
  logic signed [19:0] t2_q [3];

  logic               d_vld_q;
  logic signed [27:0] pos_q [3];
  logic signed [52:0] vp_q [3];

  logic               o_vld_q;
  logic signed [27:0] o_pos_q [3];
  logic signed [24:0] o_vel_q [3];
  logic               o_sat_q;

  logic signed [63:0] vr [3];
  logic [2:0]         sat;

  osti_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  assign adv        = !o_vld_q || !out_stall_i;
  assign in_stall_o = coef.busy || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign sc_a = osti_pkg::cordic_finish(cord_q[NSt-1].x, cord_q[NSt-1].y,
                                        quad_q[NSt-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSt; i++) begin
        vld_q[i] <= 1'b0;
      end
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= accept;
      for (int i = 0; i < NSt - 1; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
      a_vld_q <= vld_q[NSt-1];
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      o_vld_q <= d_vld_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vr[k]  = osti_pkg::rnd64(64'(vp_q[k]), 16);
      sat[k] = (vr[k] > osti_pkg::VEL_MAX) || (vr[k] < -osti_pkg::VEL_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cord_q[0] <= osti_pkg::cordic_init(true_anomaly_i);
      quad_q[0] <= true_anomaly_i[15:14];
      r_q[0]    <= orbit_radius_i;
      for (int i = 0; i < NSt - 1; i++) begin
        cord_q[i+1] <= osti_pkg::cordic_step(cord_q[i], 5'(i));
        quad_q[i+1] <= quad_q[i];
        r_q[i+1]    <= r_q[i];
      end

      cv_q  <= sc_a.c;
      sv_q  <= sc_a.s;
      vx_q  <= -sc_a.s;
      vy_q  <= $signed({3'b000, coef.ecc}) + 19'(sc_a.c);
      a_r_q <= r_q[NSt-1];

      for (int k = 0; k < 3; k++) begin
        t_q[k] <= 35'($signed(coef.m[2*k]) * cv_q + $signed(coef.m[2*k+1]) * sv_q);
        u_q[k] <= 36'(37'($signed(coef.m[2*k]) * vx_q)
                      + 37'($signed(coef.m[2*k+1]) * vy_q));
      end
      b_r_q <= a_r_q;

      for (int k = 0; k < 3; k++) begin
        pl_q[k] <= b_r_q * t_q[k][16:0];
        ph_q[k] <= 45'($signed({1'b0, b_r_q}) * $signed(t_q[k][34:17]));
        t2_q[k] <= 20'(osti_pkg::rnd64(64'(u_q[k]), 16));
      end

      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= 28'(osti_pkg::clamp64(
                      osti_pkg::rnd64((64'(ph_q[k]) <<< 17) + $signed(64'(pl_q[k])), 32),
                      osti_pkg::POS_MAX));
        vp_q[k]  <= $signed({1'b0, coef.scale}) * t2_q[k];
      end

      for (int k = 0; k < 3; k++) begin
        o_pos_q[k] <= pos_q[k];
        o_vel_q[k] <= 25'(osti_pkg::clamp64(vr[k], osti_pkg::VEL_MAX));
      end
      o_sat_q <= |sat;
    end
  end

  assign out_valid_o     = o_vld_q;
  assign pos_x_o         = o_pos_q[0];
  assign pos_y_o         = o_pos_q[1];
  assign pos_z_o         = o_pos_q[2];
  assign vel_x_o         = o_vel_q[0];
  assign vel_y_o         = o_vel_q[1];
  assign vel_z_o         = o_vel_q[2];
  assign vel_saturated_o = o_sat_q;

  // a clamped item has some component at full scale
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vel_saturated_o |->
      vel_x_o == 25'sd16777215 || vel_x_o == -25'sd16777215 ||
      vel_y_o == 25'sd16777215 || vel_y_o == -25'sd16777215 ||
      vel_z_o == 25'sd16777215 || vel_z_o == -25'sd16777215)
    else $error("saturation flag without a clamped velocity");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_x_o != 28'sh8000000 && pos_y_o != 28'sh8000000 &&
      pos_z_o != 28'sh8000000)
    else $error("position outside clamp range");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef.busy |-> in_stall_o)
    else $error("item taken while coefficients are being computed");

endmodule

/* hw/rtl/osti_coef.sv */
module osti_coef (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [49:0]            cfg_wdata_i,
  output osti_pkg::coef_t        coef_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CORD = 6'b000010,
    ST_MAT  = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_SQRT = 6'b100000
  } cst_e;

  logic [15:0] argp_q, incl_q, node_q, ecc_q;
  logic [26:0] sma_q;
  logic [49:0] mu_q;
  logic        cfg_hit;

  cst_e        state_q, state_d;
  logic        pend_q, pend_d;
  logic [1:0]  ang_q, ang_d;
  logic [4:0]  step_q, step_d;
  logic [2:0]  ent_q, ent_d;
  logic [1:0]  ph_q, ph_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [6:0]  k_q, k_d;
  logic [4:0]  sqi_q, sqi_d;

  osti_pkg::cord_t cord_q, cord_nx;
  osti_pkg::sc_t   sc_q [3];
  osti_pkg::sc_t   sc_new;
  logic [15:0]     ang_val, ang_next_val;

  logic signed [17:0] opa, opb, opc, ope;
  logic signed [35:0] p1_q, p2_q;
  logic signed [17:0] eop_q;
  logic signed [53:0] pe;
  logic signed [63:0] acc_q;
  logic [5:0][17:0]   m_q;

  logic [31:0] e2_q, dlo_q;
  logic        dhi_q;
  logic [38:0] mlo_q, mhi_q;
  logic [63:0] mm_q;
  logic [58:0] pa;
  logic [59:0] p_q;
  logic [59:0] rem_q, rem_nx;
  logic [60:0] rs;
  logic        ge;
  logic [63:0] msh_q, quo_q, quo_nx;
  logic        over_q, over_nx;
  logic [63:0] n_q, root_q, n_nx, root_nx, sbit, trial;
  logic        sge;
  logic [31:0] scale_q;

  always_comb begin
    case (cfg_idx_i)
      osti_pkg::CFG_ARGP, osti_pkg::CFG_INCL, osti_pkg::CFG_NODE,
      osti_pkg::CFG_SMA, osti_pkg::CFG_ECC, osti_pkg::CFG_MU: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      argp_q <= '0;
      incl_q <= '0;
      node_q <= '0;
      sma_q  <= 27'd6778000;
      ecc_q  <= '0;
      mu_q   <= 50'd398600441800000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        osti_pkg::CFG_ARGP: argp_q <= cfg_wdata_i[15:0];
        osti_pkg::CFG_INCL: incl_q <= cfg_wdata_i[15:0];
        osti_pkg::CFG_NODE: node_q <= cfg_wdata_i[15:0];
        osti_pkg::CFG_SMA:  sma_q  <= cfg_wdata_i[26:0];
        osti_pkg::CFG_ECC:  ecc_q  <= cfg_wdata_i[15:0];
        osti_pkg::CFG_MU:   mu_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ang_q)
      2'd0: begin
        ang_val      = argp_q;
        ang_next_val = incl_q;
      end
      2'd1: begin
        ang_val      = incl_q;
        ang_next_val = node_q;
      end
      default: begin
        ang_val      = node_q;
        ang_next_val = node_q;
      end
    endcase
  end

  assign cord_nx = osti_pkg::cordic_step(cord_q, step_q);
  assign sc_new  = osti_pkg::cordic_finish(cord_nx.x, cord_nx.y, ang_val[15:14]);

  // rotation entry operands: a*b*2^16 + (c*ci)*e
  always_comb begin
    case (ent_q)
      3'd0: begin
        opa = sc_q[2].c;  opb = sc_q[0].c;  opc = -sc_q[2].s; ope = sc_q[0].s;
      end
      3'd1: begin
        opa = -sc_q[2].c; opb = sc_q[0].s;  opc = -sc_q[2].s; ope = sc_q[0].c;
      end
      3'd2: begin
        opa = sc_q[2].s;  opb = sc_q[0].c;  opc = sc_q[2].c;  ope = sc_q[0].s;
      end
      3'd3: begin
        opa = -sc_q[2].s; opb = sc_q[0].s;  opc = sc_q[2].c;  ope = sc_q[0].c;
      end
      3'd4: begin
        opa = sc_q[1].s;  opb = sc_q[0].s;  opc = '0;         ope = '0;
      end
      3'd5: begin
        opa = sc_q[1].s;  opb = sc_q[0].c;  opc = '0;         ope = '0;
      end
      default: begin
        opa = '0;         opb = '0;         opc = '0;         ope = '0;
      end
    endcase
  end

  assign pe = p2_q * eop_q;
  assign pa = sma_q * dlo_q;

  // restoring division step
  assign rs      = {rem_q, msh_q[63]};
  assign ge      = rs >= {1'b0, p_q};
  assign rem_nx  = ge ? 60'(rs - {1'b0, p_q}) : rs[59:0];
  assign quo_nx  = {quo_q[62:0], ge};
  assign over_nx = over_q | (ge & k_q[6]);

  // square root step
  assign sbit    = 64'd1 << (7'd62 - {1'b0, sqi_q, 1'b0});
  assign trial   = root_q + sbit;
  assign sge     = n_q >= trial;
  assign n_nx    = sge ? n_q - trial : n_q;
  assign root_nx = sge ? (root_q >> 1) + sbit : root_q >> 1;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    ang_d   = ang_q;
    step_d  = step_q;
    ent_d   = ent_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    sqi_d   = sqi_q;
    case (state_q)
      ST_IDLE: begin
        if (pend_q) begin
          state_d = ST_CORD;
          pend_d  = 1'b0;
          ang_d   = '0;
          step_d  = '0;
        end
      end
      ST_CORD: begin
        if (step_q == 5'(osti_pkg::CordSteps - 1)) begin
          step_d = '0;
          if (ang_q == 2'd2) begin
            state_d = ST_MAT;
            ent_d   = '0;
            ph_d    = '0;
          end else begin
            ang_d = ang_q + 2'd1;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_MAT: begin
        if (ph_q == 2'd2) begin
          ph_d = '0;
          if (ent_q == 3'd5) begin
            state_d = ST_PREP;
            cnt_d   = '0;
          end else begin
            ent_d = ent_q + 3'd1;
          end
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      ST_PREP: begin
        if (cnt_q == 2'd3) begin
          if (p_q == '0 || mm_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DIV;
            k_d     = 7'd101;
          end
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_DIV: begin
        if (k_q == '0) begin
          if (over_nx) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SQRT;
            sqi_d   = '0;
          end
        end else begin
          k_d = k_q - 7'd1;
        end
      end
      ST_SQRT: begin
        if (sqi_q == 5'd31) begin
          state_d = ST_IDLE;
        end else begin
          sqi_d = sqi_q + 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i && cfg_hit) begin
      pend_d  = 1'b1;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b1;
      ang_q   <= '0;
      step_q  <= '0;
      ent_q   <= '0;
      ph_q    <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      sqi_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      ang_q   <= ang_d;
      step_q  <= step_d;
      ent_q   <= ent_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      sqi_q   <= sqi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: cord_q <= osti_pkg::cordic_init(argp_q);
      ST_CORD: begin
        if (step_q == 5'(osti_pkg::CordSteps - 1)) begin
          sc_q[ang_q] <= sc_new;
          cord_q      <= osti_pkg::cordic_init(ang_next_val);
        end else begin
          cord_q <= cord_nx;
        end
      end
      ST_MAT: begin
        case (ph_q)
          2'd0: begin
            p1_q  <= opa * opb;
            p2_q  <= opc * sc_q[1].c;
            eop_q <= ope;
          end
          2'd1: acc_q <= (64'(p1_q) <<< 16) + 64'(pe);
          default: m_q[ent_q] <= 18'(osti_pkg::clamp64(osti_pkg::rnd64(acc_q, 32),
                                                       osti_pkg::COEF_ONE));
        endcase
      end
      ST_PREP: begin
        case (cnt_q)
          2'd0: begin
            e2_q  <= ecc_q * ecc_q;
            mlo_q <= mu_q[24:0] * 14'd15625;
            mhi_q <= mu_q[49:25] * 14'd15625;
          end
          2'd1: begin
            dlo_q <= 32'd0 - e2_q;
            dhi_q <= e2_q == '0;
            mm_q  <= (64'(mhi_q) << 25) + 64'(mlo_q);
          end
          2'd2: p_q <= 60'(pa) + (dhi_q ? (60'(sma_q) << 32) : 60'd0);
          default: begin
            rem_q  <= '0;
            msh_q  <= mm_q;
            quo_q  <= '0;
            over_q <= 1'b0;
            if (p_q == '0 || mm_q == '0) begin
              scale_q <= '0;
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_q  <= rem_nx;
        quo_q  <= quo_nx;
        over_q <= over_nx;
        msh_q  <= msh_q << 1;
        if (k_q == '0) begin
          n_q    <= quo_nx;
          root_q <= '0;
          if (over_nx) begin
            scale_q <= '1;
          end
        end
      end
      ST_SQRT: begin
        n_q    <= n_nx;
        root_q <= root_nx;
        if (sqi_q == 5'd31) begin
          scale_q <= root_nx[31:0];
        end
      end
      default: ;
    endcase
  end

  assign coef_o.busy  = pend_q || (state_q != ST_IDLE);
  assign coef_o.scale = scale_q;
  assign coef_o.ecc   = ecc_q;
  assign coef_o.m     = m_q;

endmodule
